// ===== sv/mct_pkg.sv =====
`default_nettype none

package mct_pkg;

   localparam int FUNC_W     = 2;
   localparam int NODE_ID_W  = 4;
   localparam int VALUE_W    = 32;
   localparam int CNT_REG_W  = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_OWN_NODE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NODE_COUNT = 2'd1;

   localparam logic [NODE_ID_W-1:0] OWN_NODE_RESET   = 4'd0;
   localparam logic [CNT_REG_W-1:0] NODE_COUNT_RESET = 5'd16;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_TICK  = 2'd0,
      FUNC_MERGE = 2'd1,
      FUNC_QUERY = 2'd2,
      FUNC_NONE  = 2'd3
   } func_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_CLR,
      OP_LOAD,
      OP_RD_DIAG,
      OP_WR_INC,
      OP_RD_OWN,
      OP_WR_MAX_OWN,
      OP_RD_CELL,
      OP_WR_MAX_CELL,
      OP_SWEEP,
      OP_RESP
   } op_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DISPATCH,
      ST_TICK_RD,
      ST_TICK_WR,
      ST_OWN_RD,
      ST_OWN_WR,
      ST_CELL_RD,
      ST_CELL_WR,
      ST_SWEEP,
      ST_DIAG_RD,
      ST_RESP
   } state_type;

   typedef struct packed {
      func_type func;
      logic     me_ok;
      logic     own_ok;
      logic     cell_ok;
      logic     origin_ok;
      logic     clr_last;
      logic     sweep_last;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== sv/mct_csr.sv =====
`default_nettype none

module mct_csr
   import mct_pkg::*;
#(
   parameter int MAX_NODES = 16,
   parameter int SITE_W    = 5
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   output logic [NODE_ID_W-1:0]       own_node,
   output logic [SITE_W-1:0]          active_n
);

   logic [NODE_ID_W-1:0] own_node_ff;
   logic [CNT_REG_W-1:0] node_count_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_node_ff   <= OWN_NODE_RESET;
         node_count_ff <= NODE_COUNT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_OWN_NODE:   own_node_ff   <= csr_data[NODE_ID_W-1:0];
            CSR_NODE_COUNT: node_count_ff <= csr_data[CNT_REG_W-1:0];
            default: ;
         endcase
      end
   end

   // zero sites acts as one, too many acts as the table size
   always_comb begin
      if (node_count_ff == '0) begin
         active_n = SITE_W'(1);
      end else if (SITE_W'(node_count_ff) > SITE_W'(MAX_NODES)) begin
         active_n = SITE_W'(MAX_NODES);
      end else begin
         active_n = SITE_W'(node_count_ff);
      end
   end

   assign own_node = own_node_ff;

endmodule

`default_nettype wire

// ===== sv/mct_ctrl.sv =====
`default_nettype none

module mct_ctrl
   import mct_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   output logic               busy,
   input  wire dp_status_type status,
   output op_type             op
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            unique case (status.func)
               FUNC_TICK:  state_in = status.me_ok ? ST_TICK_RD : ST_DIAG_RD;
               FUNC_MERGE: begin
                  if (status.own_ok) begin
                     state_in = ST_OWN_RD;
                  end else if (status.cell_ok) begin
                     state_in = ST_CELL_RD;
                  end else begin
                     state_in = ST_DIAG_RD;
                  end
               end
               FUNC_QUERY: state_in = status.origin_ok ? ST_SWEEP : ST_DIAG_RD;
               default:    state_in = ST_DIAG_RD;
            endcase
         end
         ST_TICK_RD: state_in = ST_TICK_WR;
         ST_TICK_WR: state_in = ST_DIAG_RD;
         ST_OWN_RD:  state_in = ST_OWN_WR;
         // own row update implies the addressed element is active too
         ST_OWN_WR:  state_in = ST_CELL_RD;
         ST_CELL_RD: state_in = ST_CELL_WR;
         ST_CELL_WR: state_in = ST_DIAG_RD;
         ST_SWEEP: begin
            if (status.sweep_last) state_in = ST_DIAG_RD;
         end
         ST_DIAG_RD: state_in = ST_RESP;
         ST_RESP:    state_in = ST_IDLE;
         default:    state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      op = OP_NONE;
      unique case (state_ff)
         ST_CLEAR:    op = OP_CLR;
         ST_IDLE:     op = start ? OP_LOAD : OP_NONE;
         ST_DISPATCH: op = OP_NONE;
         ST_TICK_RD:  op = OP_RD_DIAG;
         ST_TICK_WR:  op = OP_WR_INC;
         ST_OWN_RD:   op = OP_RD_OWN;
         ST_OWN_WR:   op = OP_WR_MAX_OWN;
         ST_CELL_RD:  op = OP_RD_CELL;
         ST_CELL_WR:  op = OP_WR_MAX_CELL;
         ST_SWEEP:    op = OP_SWEEP;
         ST_DIAG_RD:  op = OP_RD_DIAG;
         ST_RESP:     op = OP_RESP;
         default:     op = OP_NONE;
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

// ===== sv/mct_dp.sv =====
`default_nettype none

module mct_dp
   import mct_pkg::*;
#(
   parameter int MAX_NODES   = 16,
   parameter int COUNT_WIDTH = 32,
   parameter int SITE_W      = 5
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire op_type               op,
   output dp_status_type             status,
   input  wire logic [FUNC_W-1:0]    req_func,
   input  wire logic [NODE_ID_W-1:0] req_row,
   input  wire logic [NODE_ID_W-1:0] req_col,
   input  wire logic [VALUE_W-1:0]   req_value,
   input  wire logic [NODE_ID_W-1:0] req_sender,
   input  wire logic [NODE_ID_W-1:0] req_origin,
   input  wire logic [VALUE_W-1:0]   req_stamp,
   input  wire logic [NODE_ID_W-1:0] req_target,
   input  wire logic [NODE_ID_W-1:0] own_node,
   input  wire logic [SITE_W-1:0]    active_n,
   output logic                      rsp_valid,
   output logic [VALUE_W-1:0]        rsp_new_count,
   output logic                      rsp_known_by_target,
   output logic                      rsp_known_by_all
);

   localparam int NODE_W    = $clog2(MAX_NODES);
   localparam int ADDR_W    = 2 * NODE_W;
   localparam int MEM_DEPTH = 1 << ADDR_W;
   localparam int CMP_W     = (COUNT_WIDTH > VALUE_W) ? COUNT_WIDTH : VALUE_W;

   logic [COUNT_WIDTH-1:0] mem [MEM_DEPTH];
   logic [COUNT_WIDTH-1:0] rdata_ff;

   func_type               func_ff;
   logic [NODE_ID_W-1:0]   row_ff;
   logic [NODE_ID_W-1:0]   col_ff;
   logic [COUNT_WIDTH-1:0] value_ff;
   logic [NODE_ID_W-1:0]   sender_ff;
   logic [NODE_ID_W-1:0]   origin_ff;
   logic [VALUE_W-1:0]     stamp_ff;
   logic [NODE_ID_W-1:0]   target_ff;

   logic [ADDR_W-1:0]      clr_ff;
   logic [NODE_W-1:0]      sweep_k_ff;
   logic [NODE_W-1:0]      pend_k_ff;
   logic                   pend_ff;
   logic                   all_ff;
   logic                   tgt_ff;

   logic                   rsp_valid_ff;
   logic [VALUE_W-1:0]     rsp_new_count_ff;
   logic                   rsp_known_by_target_ff;
   logic                   rsp_known_by_all_ff;

   logic [CMP_W-1:0]       value_ext;
   logic [COUNT_WIDTH-1:0] value_sat;
   logic [NODE_W-1:0]      me_idx;
   logic [ADDR_W-1:0]      addr;
   logic                   rd_en;
   logic                   wr_en;
   logic [COUNT_WIDTH-1:0] wr_data;
   logic                   stamp_ge;
   logic                   me_ok;
   logic                   cell_ok;
   logic                   origin_ok;

   // received values wider than a count saturate
   assign value_ext = CMP_W'(req_value);
   assign value_sat = (value_ext > CMP_W'({COUNT_WIDTH{1'b1}})) ? '1
                                                                 : COUNT_WIDTH'(value_ext);

   assign me_idx    = NODE_W'(own_node);
   assign me_ok     = SITE_W'(own_node) < active_n;
   assign cell_ok   = (SITE_W'(row_ff) < active_n) && (SITE_W'(col_ff) < active_n);
   assign origin_ok = SITE_W'(origin_ff) < active_n;
   assign stamp_ge  = CMP_W'(rdata_ff) >= CMP_W'(stamp_ff);

   always_comb begin
      status.func       = func_ff;
      status.me_ok      = me_ok;
      status.cell_ok    = cell_ok;
      status.own_ok     = cell_ok && me_ok && (row_ff == sender_ff);
      status.origin_ok  = origin_ok;
      status.clr_last   = &clr_ff;
      status.sweep_last = SITE_W'(sweep_k_ff) == (active_n - SITE_W'(1));
   end

   always_comb begin
      addr  = '0;
      rd_en = 1'b0;
      wr_en = 1'b0;
      unique case (op) inside
         OP_CLR: begin
            addr  = clr_ff;
            wr_en = 1'b1;
         end
         OP_RD_DIAG, OP_WR_INC: begin
            addr  = {me_idx, me_idx};
            rd_en = (op == OP_RD_DIAG);
            wr_en = (op == OP_WR_INC);
         end
         OP_RD_OWN, OP_WR_MAX_OWN: begin
            addr  = {me_idx, NODE_W'(col_ff)};
            rd_en = (op == OP_RD_OWN);
            wr_en = (op == OP_WR_MAX_OWN);
         end
         OP_RD_CELL, OP_WR_MAX_CELL: begin
            addr  = {NODE_W'(row_ff), NODE_W'(col_ff)};
            rd_en = (op == OP_RD_CELL);
            wr_en = (op == OP_WR_MAX_CELL);
         end
         OP_SWEEP: begin
            addr  = {sweep_k_ff, NODE_W'(origin_ff)};
            rd_en = 1'b1;
         end
         default: ;
      endcase
   end

   always_comb begin
      case (op)
         OP_CLR:    wr_data = '0;
         OP_WR_INC: wr_data = (&rdata_ff) ? rdata_ff : rdata_ff + COUNT_WIDTH'(1);
         default:   wr_data = (value_ff > rdata_ff) ? value_ff : rdata_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[addr] <= wr_data;
      if (rd_en) rdata_ff <= mem[addr];
   end

   always_ff @(posedge clock) begin
      if (op == OP_LOAD) begin
         func_ff   <= func_type'(req_func);
         row_ff    <= req_row;
         col_ff    <= req_col;
         value_ff  <= value_sat;
         sender_ff <= req_sender;
         origin_ff <= req_origin;
         stamp_ff  <= req_stamp;
         target_ff <= req_target;
         all_ff    <= 1'b1;
         tgt_ff    <= 1'b0;
      end else if (pend_ff) begin
         // sweep data lands in the cycle after its read
         if (!stamp_ge) all_ff <= 1'b0;
         if (SITE_W'(pend_k_ff) == SITE_W'(target_ff)) tgt_ff <= stamp_ge;
      end
      pend_k_ff <= sweep_k_ff;
      if (op == OP_RESP) begin
         rsp_new_count_ff       <= me_ok ? VALUE_W'(rdata_ff) : '0;
         rsp_known_by_target_ff <= (func_ff == FUNC_QUERY) && origin_ok && tgt_ff;
         rsp_known_by_all_ff    <= (func_ff == FUNC_QUERY) && origin_ok && all_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         sweep_k_ff   <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (op == OP_CLR) clr_ff <= clr_ff + ADDR_W'(1);
         if (op == OP_LOAD) begin
            sweep_k_ff <= '0;
         end else if (op == OP_SWEEP) begin
            sweep_k_ff <= sweep_k_ff + NODE_W'(1);
         end
         pend_ff      <= (op == OP_SWEEP);
         rsp_valid_ff <= (op == OP_RESP);
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_new_count       = rsp_new_count_ff;
   assign rsp_known_by_target = rsp_known_by_target_ff;
   assign rsp_known_by_all    = rsp_known_by_all_ff;

endmodule

`default_nettype wire

// ===== sv/matrix_clock_table_unit.sv =====
`default_nettype none

// Matrix clock of MAX_NODES x MAX_NODES event counts held in one single-port
// table memory; every access goes through that one read/write port, which sets
// the item time. After reset the table is swept to zero, one entry per cycle,
// over all 2^(2*ceil(log2(MAX_NODES))) entries (256 by default), busy high.
// An item is taken when start is high and busy is low; busy stays high until
// the result is issued, then drops in the cycle rsp_valid is shown, so a new
// item can be taken in that same cycle. A tick increments the own diagonal
// entry (not when the own site is not active), a merge read-modify-writes
// the addressed cell (and the own row entry first when that is updated too),
// a query reads one column entry per active site (none when origin is not
// active). rsp_valid is high for exactly one cycle per item and cannot be held
// off, so the receiver must capture the result in that cycle. Configuration
// writes are always ready and are meant for when the block is idle.
module matrix_clock_table_unit
   import mct_pkg::*;
#(
   parameter int MAX_NODES   = 16,
   parameter int COUNT_WIDTH = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic [FUNC_W-1:0]     req_func,
   input  wire logic [NODE_ID_W-1:0]  req_row,
   input  wire logic [NODE_ID_W-1:0]  req_col,
   input  wire logic [VALUE_W-1:0]    req_value,
   input  wire logic [NODE_ID_W-1:0]  req_sender,
   input  wire logic [NODE_ID_W-1:0]  req_origin,
   input  wire logic [VALUE_W-1:0]    req_stamp,
   input  wire logic [NODE_ID_W-1:0]  req_target,
   output logic                       rsp_valid,
   output logic [VALUE_W-1:0]         rsp_new_count,
   output logic                       rsp_known_by_target,
   output logic                       rsp_known_by_all,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   localparam int SITE_W = ($clog2(MAX_NODES + 1) > CNT_REG_W) ? $clog2(MAX_NODES + 1)
                                                               : CNT_REG_W;

   logic [NODE_ID_W-1:0] own_node;
   logic [SITE_W-1:0]    active_n;
   dp_status_type        status;
   op_type               op;

   mct_csr #(
      .MAX_NODES (MAX_NODES),
      .SITE_W    (SITE_W)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .own_node  (own_node),
      .active_n  (active_n)
   );

   mct_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .op     (op)
   );

   mct_dp #(
      .MAX_NODES   (MAX_NODES),
      .COUNT_WIDTH (COUNT_WIDTH),
      .SITE_W      (SITE_W)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .op                  (op),
      .status              (status),
      .req_func            (req_func),
      .req_row             (req_row),
      .req_col             (req_col),
      .req_value           (req_value),
      .req_sender          (req_sender),
      .req_origin          (req_origin),
      .req_stamp           (req_stamp),
      .req_target          (req_target),
      .own_node            (own_node),
      .active_n            (active_n),
      .rsp_valid           (rsp_valid),
      .rsp_new_count       (rsp_new_count),
      .rsp_known_by_target (rsp_known_by_target),
      .rsp_known_by_all    (rsp_known_by_all)
   );

   // one result per item, never on back-to-back cycles
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("rsp_valid held for more than one cycle");

   // a result is issued only once the controller is back to idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result issued while busy");

   // a newly taken item cannot produce its result in the next cycle
   a_accept_gap: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_valid))
      else $error("item accepted without entering the busy phase");

endmodule

`default_nettype wire
